// File: src/tdfa_pkg.sv
// Package for the table-driven DFA matcher: field widths, command, verdict and
// register codes, and the write request carried to the transition memory.
// No dependencies.
package tdfa_pkg;

  // Default sizes of the alphabet and the transition table.
  localparam int NUM_STATES_DEF  = 16;
  localparam int MAX_SYMBOLS_DEF = 16;

  // Fixed field widths.
  localparam int STATE_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 2;
  localparam int VERDICT_W  = 2;
  localparam int SYM_CNT_W  = 5;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Commands carried in tuser.
  localparam logic [CMD_W-1:0] CMD_LOAD_ALPHA = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TRANS = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SYMBOL     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END        = 2'd3;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_PROGRESS = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECT   = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_INVALID  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK    = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SYM_CNT_W-1:0] SYM_USED_RST = 5'd16;
  localparam logic [STATE_W-1:0]   START_RST    = 4'd0;

  // One transition table write.
  typedef struct packed {
    logic               en;
    logic [STATE_W-1:0] row;
    logic [STATE_W-1:0] col;
    logic [STATE_W-1:0] val;
  } tdfa_wr_t;

endpackage

// File: src/tdfa_trans_mem.sv
// Transition table of the DFA matcher: one row of next states per source state,
// written one entry at a time and read a whole row per cycle into a register.
// Depends on tdfa_pkg.
module tdfa_trans_mem #(
  parameter int NUM_STATES  = tdfa_pkg::NUM_STATES_DEF,
  parameter int MAX_SYMBOLS = tdfa_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tdfa_pkg::tdfa_wr_t                    wr_i,
  input  logic [tdfa_pkg::STATE_W-1:0]          rd_state_i,
  output logic [MAX_SYMBOLS*tdfa_pkg::STATE_W-1:0] row_o
);
  import tdfa_pkg::*;

  localparam int StIdxW  = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int SymIdxW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int RowW    = MAX_SYMBOLS * STATE_W;

  logic [RowW-1:0]    trans_mem_q [NUM_STATES];
  logic [RowW-1:0]    raw_q;
  logic [StIdxW-1:0]  wr_row;
  logic [StIdxW-1:0]  rd_row;
  logic [SymIdxW-1:0] wr_col;
  logic               fwd_d, fwd_q;
  logic [SymIdxW-1:0] fwd_col_q;
  logic [STATE_W-1:0] fwd_val_q;

  assign wr_row = StIdxW'(wr_i.row);
  assign rd_row = StIdxW'(rd_state_i);
  assign wr_col = SymIdxW'(wr_i.col);

  // A write to the row being read lands after the read, so it is forwarded.
  assign fwd_d = wr_i.en && (wr_i.row == rd_state_i);

  // Memory write of one entry and registered read of a whole row.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < MAX_SYMBOLS; c++) begin
      if (wr_i.en && (wr_col == SymIdxW'(c))) begin
        trans_mem_q[wr_row][c*STATE_W +: STATE_W] <= wr_i.val;
      end
    end
    raw_q     <= trans_mem_q[rd_row];
    fwd_col_q <= wr_col;
    fwd_val_q <= wr_i.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= fwd_d;
    end
  end

  // Row as seen by the next cycle, with the forwarded entry merged in.
  always_comb begin
    for (int c = 0; c < MAX_SYMBOLS; c++) begin
      if (fwd_q && (fwd_col_q == SymIdxW'(c))) begin
        row_o[c*STATE_W +: STATE_W] = fwd_val_q;
      end else begin
        row_o[c*STATE_W +: STATE_W] = raw_q[c*STATE_W +: STATE_W];
      end
    end
  end

endmodule

// File: src/table_driven_dfa_matcher_top.sv
// Table-driven DFA matcher. The block takes one transaction per clock cycle in
// a steady stream while the result stream does not stall, and passes each one
// through the input register, then the result register. In the state loop the
// alphabet compare picks a column of the transition row held in a register,
// and that row register is refilled every cycle from the transition memory at
// the next state. Loads produce no result; symbols and end of string give one.
// Depends on tdfa_pkg and tdfa_trans_mem.
module table_driven_dfa_matcher_top #(
  parameter int NUM_STATES  = tdfa_pkg::NUM_STATES_DEF,
  parameter int MAX_SYMBOLS = tdfa_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [tdfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tdfa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: table_row[3:0], table_column[7:4], entry_value[15:8], symbol_char[23:16]
  input  logic [tdfa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: command[1:0]
  input  logic [tdfa_pkg::CMD_W-1:0]        s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: state_now[3:0], verdict[5:4], zero[7:6]
  output logic [tdfa_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tlast: string_done
  output logic                              m_axis_tlast
);
  import tdfa_pkg::*;

  localparam int SymIdxW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int UsedW   = ($clog2(MAX_SYMBOLS + 1) > SYM_CNT_W) ?
                           $clog2(MAX_SYMBOLS + 1) : SYM_CNT_W;
  localparam int RowW    = MAX_SYMBOLS * STATE_W;

  // Configuration registers.
  logic [SYM_CNT_W-1:0] sym_used_q;
  logic [STATE_W-1:0]   start_q;
  logic [MASK_W-1:0]    accept_q;

  // Input register.
  logic               s1_valid_q, s1_valid_d;
  logic [CMD_W-1:0]   s1_cmd_q;
  logic [STATE_W-1:0] s1_row_q, s1_col_q;
  logic [CHAR_W-1:0]  s1_val_q, s1_char_q;

  // Matcher state.
  logic               bad_q, bad_d;
  logic [STATE_W-1:0] state_q, state_d;
  logic [CHAR_W-1:0]  alpha_q [MAX_SYMBOLS];

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic [STATE_W-1:0]   out_state_q, res_state;
  logic [VERDICT_W-1:0] out_verdict_q, res_verdict;
  logic                 out_last_q, res_last;

  logic               in_fire, s1_fire, s1_has_res, out_free;
  logic               row_ok, col_ok, state_ok;
  logic               found;
  logic [SymIdxW-1:0] hit;
  logic [STATE_W-1:0] next_state;
  logic [RowW-1:0]    cur_row;
  tdfa_wr_t           wr;

  // Configuration writes; an unused index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_used_q <= SYM_USED_RST;
      start_q    <= START_RST;
      accept_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SYMBOLS_IN_USE: sym_used_q <= cfg_data_i[SYM_CNT_W-1:0];
        CFG_START_STATE:    start_q    <= cfg_data_i[STATE_W-1:0];
        CFG_ACCEPT_MASK:    accept_q   <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register drains unless a result finds the output full.
  assign s1_has_res    = (s1_cmd_q == CMD_SYMBOL) || (s1_cmd_q == CMD_END);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && (!s1_has_res || out_free);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= s_axis_tuser;
      s1_row_q  <= s_axis_tdata[3:0];
      s1_col_q  <= s_axis_tdata[7:4];
      s1_val_q  <= s_axis_tdata[15:8];
      s1_char_q <= s_axis_tdata[23:16];
    end
  end

  // Load indexes beyond the table are dropped.
  assign row_ok   = 32'(s1_row_q) < NUM_STATES;
  assign col_ok   = 32'(s1_col_q) < MAX_SYMBOLS;
  assign state_ok = 32'(state_q) < NUM_STATES;

  // Alphabet store.
  always_ff @(posedge clk_i) begin
    if (s1_fire && (s1_cmd_q == CMD_LOAD_ALPHA) && col_ok) begin
      alpha_q[SymIdxW'(s1_col_q)] <= s1_val_q;
    end
  end

  // Parallel alphabet compare; the lowest matching entry in use wins.
  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if ((UsedW'(k) < UsedW'(sym_used_q)) && (alpha_q[k] == s1_char_q)) begin
        found = 1'b1;
        hit   = SymIdxW'(k);
      end
    end
  end

  // Column select from the row of the current state.
  always_comb begin
    next_state = '0;
    for (int k = 0; k < MAX_SYMBOLS; k++) begin
      if (hit == SymIdxW'(k)) begin
        next_state = cur_row[k*STATE_W +: STATE_W];
      end
    end
  end

  // Transition table writes and the row read for the following cycle.
  always_comb begin
    wr.en  = s1_fire && (s1_cmd_q == CMD_LOAD_TRANS) && row_ok && col_ok;
    wr.row = s1_row_q;
    wr.col = s1_col_q;
    wr.val = s1_val_q[STATE_W-1:0];
  end

  tdfa_trans_mem #(
    .NUM_STATES  (NUM_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_trans_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_state_i (state_d),
    .row_o      (cur_row)
  );

  // State step and result for symbol and end-of-string transactions.
  always_comb begin
    state_d     = state_q;
    bad_d       = bad_q;
    res_state   = state_q;
    res_verdict = VERDICT_PROGRESS;
    res_last    = 1'b0;
    unique case (s1_cmd_q)
      CMD_SYMBOL: begin
        if (!found) begin
          bad_d = 1'b1;
        end else if (state_ok) begin
          state_d = next_state;
        end
        res_state   = state_d;
        res_verdict = bad_d ? VERDICT_INVALID : VERDICT_PROGRESS;
      end
      CMD_END: begin
        res_last = 1'b1;
        if (bad_q) begin
          res_verdict = VERDICT_INVALID;
        end else if (accept_q[state_q]) begin
          res_verdict = VERDICT_ACCEPT;
        end else begin
          res_verdict = VERDICT_REJECT;
        end
        state_d = start_q;
        bad_d   = 1'b0;
      end
      CMD_LOAD_ALPHA, CMD_LOAD_TRANS: ;
    endcase
    if (!s1_fire) begin
      state_d = state_q;
      bad_d   = bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= START_RST;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      bad_q   <= bad_d;
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_has_res) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_has_res) begin
      out_state_q   <= res_state;
      out_verdict_q <= res_verdict;
      out_last_q    <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_verdict_q, out_state_q};
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  // End of string returns the machine to the start state with a clean flag.
  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_cmd_q == CMD_END) |=> (state_q == $past(start_q)) && !bad_q)
    else $error("end of string did not restart the machine");

  // Loads never fill the result register.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && ((s1_cmd_q == CMD_LOAD_ALPHA) || (s1_cmd_q == CMD_LOAD_TRANS))
    |=> out_valid_q == $past(out_valid_q && !m_axis_tready))
    else $error("load transaction produced a result");

  // A pending symbol result agrees with the live state and invalid flag.
  a_symbol_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> (out_state_q == state_q) &&
    ((out_verdict_q == VERDICT_INVALID) == bad_q))
    else $error("symbol result disagrees with matcher state");

  // A result never waits in the input register while the output is free.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |-> s1_fire)
    else $error("input register stalled with the output free");
`endif

endmodule
